/* hw/rtl/dbhp_pkg.sv */
`default_nettype none

package dbhp_pkg;

   // parse phases
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_VALUE  = 2'd1,
      PH_SKIP   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // box type codes, big-endian ascii
   localparam logic [31:0] BOX_VERSION  = 32'h6270_6876;
   localparam logic [31:0] BOX_CHANNELS = 32'h6270_6863;
   localparam logic [31:0] BOX_RATE     = 32'h6270_6872;
   localparam logic [31:0] BOX_FORMAT   = 32'h6270_6866;
   localparam logic [31:0] BOX_DATA     = 32'h6270_6864;

   localparam logic [31:0] HEADER_BYTES = 32'd8;
   localparam logic [31:0] VALUE_BYTES  = 32'd4;

   // register indexes on the csr port
   localparam logic CSR_MAX_CHANNELS = 1'b0;
   localparam logic CSR_MAX_RATE     = 1'b1;

   localparam logic [3:0]  MAX_CHANNELS_RESET = 4'd8;
   localparam logic [28:0] MAX_RATE_RESET     = 29'h1FFF_FFFF;

   localparam int QUEUE_DEPTH = 4;

   // result item, status in the lowest bit
   typedef struct packed {
      logic [31:0] data_length;
      logic [28:0] rate_found;
      logic [3:0]  channels_found;
      logic        status;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);

   // unsupported or truncated file
   localparam result_type RESULT_FAIL = '{
      data_length: 32'd0, rate_found: 29'd0, channels_found: 4'd0, status: 1'b1};

endpackage

`default_nettype wire

/* hw/rtl/dbhp_parse.sv */
`default_nettype none

module dbhp_parse (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire  [7:0]           data_byte,
   input  wire                  stream_end,
   input  wire  [3:0]           max_channels,
   input  wire  [28:0]          max_rate,
   input  wire                  queue_full,
   output logic                 push,
   output dbhp_pkg::result_type result
);
   import dbhp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] skip_ff, skip_in;
   logic        version_seen_ff, version_seen_in;
   logic        format_seen_ff, format_seen_in;
   logic [3:0]  channels_ff, channels_in;
   logic [28:0] rate_ff, rate_in;

   logic        accept;
   logic [31:0] rem;
   logic [28:0] rate_div;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign rem      = size_ff - HEADER_BYTES;
   assign rate_div = value_in[31:3];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         pos_ff          <= '0;
         size_ff         <= '0;
         type_ff         <= '0;
         value_ff        <= '0;
         skip_ff         <= '0;
         version_seen_ff <= 1'b0;
         format_seen_ff  <= 1'b0;
         channels_ff     <= '0;
         rate_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         size_ff         <= size_in;
         type_ff         <= type_in;
         value_ff        <= value_in;
         skip_ff         <= skip_in;
         version_seen_ff <= version_seen_in;
         format_seen_ff  <= format_seen_in;
         channels_ff     <= channels_in;
         rate_ff         <= rate_in;
      end
   end

   // byte walk and box checks
   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      size_in         = size_ff;
      type_in         = type_ff;
      value_in        = value_ff;
      skip_in         = skip_ff;
      version_seen_in = version_seen_ff;
      format_seen_in  = format_seen_ff;
      channels_in     = channels_ff;
      rate_in         = rate_ff;
      push            = 1'b0;
      result          = RESULT_FAIL;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff < 3'd4) begin
                  size_in = {size_ff[23:0], data_byte};
               end else begin
                  type_in = {type_ff[23:0], data_byte};
               end
               pos_in = pos_ff + 3'd1;
               // last header byte: size is complete, type completes now
               if (pos_ff == 3'd7) begin
                  pos_in = '0;
                  if (size_ff < HEADER_BYTES) begin
                     push     = 1'b1;
                     phase_in = PH_DONE;
                  end else if (type_in == BOX_VERSION || type_in == BOX_CHANNELS ||
                               type_in == BOX_RATE || type_in == BOX_FORMAT) begin
                     if (rem != VALUE_BYTES) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        value_in = '0;
                        phase_in = PH_VALUE;
                     end
                  end else if (type_in == BOX_DATA) begin
                     push     = 1'b1;
                     phase_in = PH_DONE;
                     if (version_seen_ff && format_seen_ff && channels_ff != 4'd0 &&
                         rate_ff != 29'd0) begin
                        result.status         = 1'b0;
                        result.channels_found = channels_ff;
                        result.rate_found     = rate_ff;
                        result.data_length    = rem;
                     end
                  end else if (rem == 32'd0) begin
                     phase_in = PH_HEADER;
                  end else begin
                     skip_in  = rem;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_VALUE: begin
               value_in = {value_ff[23:0], data_byte};
               pos_in   = pos_ff + 3'd1;
               if (pos_ff == 3'd3) begin
                  pos_in   = '0;
                  phase_in = PH_HEADER;
                  if (type_ff == BOX_VERSION) begin
                     if (value_in != 32'd1) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        version_seen_in = 1'b1;
                     end
                  end else if (type_ff == BOX_CHANNELS) begin
                     if (value_in == 32'd0 || value_in > {28'd0, max_channels}) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        channels_in = value_in[3:0];
                     end
                  end else if (type_ff == BOX_RATE) begin
                     if (rate_div == 29'd0 || rate_div > max_rate) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        rate_in = rate_div;
                     end
                  end else begin
                     if (value_in != 32'd0) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        format_seen_in = 1'b1;
                     end
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_in == 32'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         // end of file: truncated unless a result is out, then start over
         if (stream_end) begin
            if (phase_in != PH_DONE) begin
               push   = 1'b1;
               result = RESULT_FAIL;
            end
            phase_in        = PH_HEADER;
            pos_in          = '0;
            size_in         = '0;
            type_in         = '0;
            value_in        = '0;
            skip_in         = '0;
            version_seen_in = 1'b0;
            format_seen_in  = 1'b0;
            channels_in     = '0;
            rate_in         = '0;
         end
      end
   end

`ifndef SYNTHESIS
   // a result without end of file parks the parser
   assert property (@(posedge clock) disable iff (reset)
      push && !stream_end |=> phase_ff == PH_DONE)
      else $error("parser not done after result");

   // a found data box always carries held values
   assert property (@(posedge clock) disable iff (reset)
      push && !result.status |-> result.channels_found != 4'd0 && result.rate_found != 29'd0)
      else $error("data result without channels or rate");

   // end of file returns to the first header byte
   assert property (@(posedge clock) disable iff (reset)
      accept && stream_end |=> phase_ff == PH_HEADER && pos_ff == 3'd0)
      else $error("parser not cleared at end of file");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dbhp_queue.sv */
`default_nettype none

module dbhp_queue #(
   parameter int DEPTH = dbhp_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  dbhp_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  wire                  out_ready,
   output dbhp_pkg::result_type out_data
);
   import dbhp_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

   result_type          mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                pop;

   assign full      = count_ff == DEPTH_CNT;
   assign out_valid = count_ff != '0;
   assign out_data  = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count past depth");

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dsd_box_header_parser.sv */
// dsd box header parser
// req channel: one file byte per item, req_tdata[7:0] the byte, req_tlast
// marks the last byte of the file. rsp channel: at most one item per file,
// carrying status, channel count, sample rate and data box length.
// csr port: max_channels at address 0, max_rate at address 4. The user
// writes them only while the parser is idle; the block does not enforce it.
// Throughput: one byte per cycle. The byte walk is a single parse
// register stage that accepts every cycle while the result queue has room.
// The result item is pushed into the result queue with the byte that
// completes it (last header byte, last value byte or the tlast byte).
// Results pass through a queue of QUEUE_DEPTH items; when rsp_tready is
// low the queue fills and req_tready drops only once it is full.
// Reset: parse state and queue are cleared, max_channels returns to 8 and
// max_rate to its largest value; the block accepts items in the next cycle.
`default_nettype none

module dsd_box_header_parser #(
   parameter int QUEUE_DEPTH = dbhp_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: data_byte[7:0]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,
   input  wire         req_tlast,
   // rsp_tdata: status[0], channels_found[4:1], rate_found[33:5],
   // data_length[65:34], zero fill [71:66]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dbhp_pkg::*;

   logic [3:0]  max_channels_ff;
   logic [28:0] max_rate_ff;
   logic        csr_write;
   logic        queue_full;
   logic        push;
   result_type  push_data;
   result_type  out_data;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_channels_ff <= MAX_CHANNELS_RESET;
         max_rate_ff     <= MAX_RATE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_MAX_CHANNELS: max_channels_ff <= csr_pwdata[3:0];
            CSR_MAX_RATE:     max_rate_ff     <= csr_pwdata[28:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MAX_CHANNELS: csr_prdata = {28'd0, max_channels_ff};
         CSR_MAX_RATE:     csr_prdata = {3'd0, max_rate_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // front: byte walk
   dbhp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .data_byte    (req_tdata),
      .stream_end   (req_tlast),
      .max_channels (max_channels_ff),
      .max_rate     (max_rate_ff),
      .queue_full   (queue_full),
      .push         (push),
      .result       (push_data)
   );

   // back: result queue toward rsp
   dbhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {(72 - RESULT_BITS)'(0), out_data};

endmodule

`default_nettype wire
